@@ hw/rtl/bals_pkg.sv @@
// Package for the bounded array list: action and status codes, the entry
// record held by each storage cell, and divider status.
// No dependencies; used by every other file of the block.
package bals_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int KEY_W    = 32;
  localparam int GRADE_W  = 16;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = 6;
  localparam int ECNT_W   = 7;
  localparam int CAP_W    = 7;

  localparam logic [CAP_W-1:0] CAP_RST = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_POP     = 3'd2,
    ACT_SEARCH  = 3'd3,
    ACT_AVERAGE = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] grade;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hw/rtl/bals_cell.sv @@
// One storage cell of the list ring: holds a key and a grade and takes
// its neighbor's entry on every shift. Depends on bals_pkg.
module bals_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  bals_pkg::entry_t ent_in,
  output bals_pkg::entry_t ent_q
);

  bals_pkg::entry_t ent_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent_r <= ent_in;
    end
  end

  assign ent_q = ent_r;

endmodule

@@ hw/rtl/bals_div.sv @@
// Restoring divider, one quotient bit per cycle, for the mean grade.
// Depends on bals_pkg (status struct).
module bals_div #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  output bals_pkg::div_stat_t stat,
  output logic [DVD_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

@@ hw/rtl/bounded_array_list_with_search_top.sv @@
// Bounded ordered list of up to DEPTH (key, grade) entries kept in a ring
// of DEPTH storage cells. Remove-last and unknown actions, and an append
// to a full list, go straight to the result without a sweep. Append,
// remove-by-key, search and average rotate the whole ring once, one cell
// per cycle; an average over a non-empty list then runs the bit-serial
// divider. One request is worked on at a time; the next is taken while
// the previous result waits in the output register.
// Depends on bals_pkg, bals_cell, bals_div.
module bounded_array_list_with_search_top #(
  parameter int DEPTH = bals_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: capacity
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  // request: tdata = key[31:0], grade[47:32]; tuser = action[2:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [2:0]  in_tuser,
  // result: tdata = found_index[5:0], entry_count[12:6], mean_grade[28:13]
  // tuser = status[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > bals_pkg::CAP_W) ? CW : bals_pkg::CAP_W;
  localparam int IXW  = (CW > bals_pkg::IDX_W) ? CW : bals_pkg::IDX_W;
  localparam int ECW  = (CW > bals_pkg::ECNT_W) ? CW : bals_pkg::ECNT_W;
  localparam int SW   = bals_pkg::GRADE_W + CW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [bals_pkg::CAP_W-1:0] capacity_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              step_r, step_nxt;
  logic [CW-1:0]              pos_r, pos_nxt;
  logic                       found_r, found_nxt;
  logic [SW-1:0]              sum_r, sum_nxt;

  bals_pkg::action_t          act_r;
  logic [bals_pkg::KEY_W-1:0]   req_key_r;
  logic [bals_pkg::GRADE_W-1:0] req_grade_r;

  bals_pkg::status_t             res_stat_r, res_stat_nxt;
  logic [bals_pkg::IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [bals_pkg::GRADE_W-1:0]  res_mean_r, res_mean_nxt;

  logic                          out_valid_r;
  bals_pkg::status_t             out_stat_r;
  logic [bals_pkg::IDX_W-1:0]    out_idx_r;
  logic [bals_pkg::ECNT_W-1:0]   out_cnt_r;
  logic [bals_pkg::GRADE_W-1:0]  out_mean_r;

  bals_pkg::entry_t cell_q [DEPTH];
  bals_pkg::entry_t head_ent, ahead_ent, tail_ent;
  logic             shift_en;

  logic             in_acc, out_load, div_start;
  logic             in_range, match, last_step, found_fin, room;
  logic [CW-1:0]    pos_fin;
  logic [IXW-1:0]   pos_wide;
  logic [ECW-1:0]   cnt_wide;
  bals_pkg::div_stat_t div_stat;
  logic [SW-1:0]    div_quo;

  // ---------------- storage ring ----------------
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      bals_pkg::entry_t cin;
      if (g == DEPTH - 1) begin : g_tail
        assign cin = tail_ent;
      end else begin : g_mid
        assign cin = cell_q[g+1];
      end
      bals_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .ent_in   (cin),
        .ent_q    (cell_q[g])
      );
    end
    if (DEPTH > 1) begin : g_ahead
      assign ahead_ent = cell_q[1];
    end else begin : g_noahead
      assign ahead_ent = cell_q[0];
    end
  endgenerate

  assign head_ent = cell_q[0];
  assign shift_en = (state_r == S_SWEEP);

  // step k of the sweep sees original entry k at the head; what goes into
  // the tail at step k becomes entry k after the full turn
  assign in_range  = step_r < count_r;
  assign match     = in_range && !found_r && (head_ent.key == req_key_r);
  assign last_step = step_r == CW'(DEPTH - 1);
  assign found_fin = found_r || match;
  assign pos_fin   = found_r ? pos_r : step_r;

  always_comb begin
    tail_ent = head_ent;
    unique case (act_r)
      bals_pkg::ACT_APPEND: begin
        if (step_r == count_r) begin
          tail_ent.key   = req_key_r;
          tail_ent.grade = req_grade_r;
        end
      end
      bals_pkg::ACT_REMOVE: begin
        if (found_fin) begin
          tail_ent = ahead_ent;
        end
      end
      default: begin
        tail_ent = head_ent;
      end
    endcase
  end

  // ---------------- divider ----------------
  bals_div #(
    .DVD_W (SW),
    .DVS_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // ---------------- control ----------------
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign room      = (CMPW'(count_r) < CMPW'(capacity_r)) && (count_r < CW'(DEPTH));
  assign pos_wide  = IXW'(pos_fin);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    step_nxt     = step_r;
    pos_nxt      = pos_r;
    found_nxt    = found_r;
    sum_nxt      = sum_r;
    res_stat_nxt = res_stat_r;
    res_idx_nxt  = res_idx_r;
    res_mean_nxt = res_mean_r;
    div_start    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          step_nxt     = '0;
          found_nxt    = 1'b0;
          pos_nxt      = '0;
          sum_nxt      = '0;
          res_stat_nxt = bals_pkg::ST_OK;
          res_idx_nxt  = '0;
          res_mean_nxt = '0;
          unique case (in_tuser)
            bals_pkg::ACT_APPEND: begin
              if (room) begin
                state_nxt = S_SWEEP;
              end else begin
                res_stat_nxt = bals_pkg::ST_FULL;
                state_nxt    = S_DONE;
              end
            end
            bals_pkg::ACT_REMOVE, bals_pkg::ACT_SEARCH, bals_pkg::ACT_AVERAGE: begin
              state_nxt = S_SWEEP;
            end
            bals_pkg::ACT_POP: begin
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end else begin
                res_stat_nxt = bals_pkg::ST_EMPTY;
              end
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SWEEP: begin
        step_nxt  = step_r + 1'b1;
        found_nxt = found_fin;
        pos_nxt   = pos_fin;
        if (in_range) begin
          sum_nxt = sum_r + SW'(head_ent.grade);
        end
        if (last_step) begin
          state_nxt = S_DONE;
          unique case (act_r)
            bals_pkg::ACT_APPEND: begin
              count_nxt = count_r + 1'b1;
            end
            bals_pkg::ACT_REMOVE: begin
              if (found_fin) begin
                count_nxt = count_r - 1'b1;
              end else begin
                res_stat_nxt = bals_pkg::ST_NOTFOUND;
              end
            end
            bals_pkg::ACT_SEARCH: begin
              if (found_fin) begin
                res_idx_nxt = pos_wide[bals_pkg::IDX_W-1:0];
              end else begin
                res_stat_nxt = bals_pkg::ST_NOTFOUND;
              end
            end
            bals_pkg::ACT_AVERAGE: begin
              if (count_r != '0) begin
                state_nxt = S_DIV;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        // sum_r is final here; launch once, then wait for the quotient
        if (!div_stat.busy && !div_stat.done && !found_r) begin
          div_start = 1'b1;
          found_nxt = 1'b1;
        end
        if (div_stat.done) begin
          res_mean_nxt = div_quo[bals_pkg::GRADE_W-1:0];
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // found_r doubles as "divider launched" in S_DIV; clear it on the way in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      capacity_r  <= bals_pkg::CAP_RST;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_SWEEP && state_nxt == S_DIV) begin
        found_r <= 1'b0;
      end else begin
        found_r <= found_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cnt_wide = ECW'(count_r);

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    pos_r      <= pos_nxt;
    sum_r      <= sum_nxt;
    res_stat_r <= res_stat_nxt;
    res_idx_r  <= res_idx_nxt;
    res_mean_r <= res_mean_nxt;
    if (in_acc) begin
      act_r       <= bals_pkg::action_t'(in_tuser);
      req_key_r   <= in_tdata[31:0];
      req_grade_r <= in_tdata[47:32];
    end
    if (out_load) begin
      out_stat_r <= res_stat_r;
      out_idx_r  <= res_idx_r;
      out_cnt_r  <= cnt_wide[bals_pkg::ECNT_W-1:0];
      out_mean_r <= res_mean_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {3'b000, out_mean_r, out_cnt_r, out_idx_r};

  // ---------------- checks ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_stat.busy)
    else $error("divider busy while idle");

  a_sweep_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && last_step) |=> state_r != S_SWEEP)
    else $error("sweep ran past the last cell");

endmodule

@@ bench/bals_list_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the bounded array list: watches the config, request and result
// channels, keeps its own copy of the list and checks every result in order.
// Depends on bals_pkg.
module bals_list_checker
  import bals_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [47:0]       in_tdata,
  input  logic [ACT_W-1:0]  in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [31:0]       out_tdata,
  input  logic [STAT_W-1:0] out_tuser,
  output int unsigned       fail_cnt,
  output int unsigned       pend_cnt,
  output int unsigned       req_cnt,
  output int unsigned       full_cnt,
  output int unsigned       miss_cnt,
  output int unsigned       empty_cnt
);

  typedef struct packed {
    status_t             status;
    logic [IDX_W-1:0]    found_index;
    logic [ECNT_W-1:0]   entry_count;
    logic [GRADE_W-1:0]  mean_grade;
  } list_resp_t;

  logic [KEY_W-1:0]   key_tab   [DEPTH];
  logic [GRADE_W-1:0] grade_tab [DEPTH];
  int unsigned        n_ent;
  logic [CAP_W-1:0]   cap_q;
  list_resp_t         resp_q [$];

  // first slot holding k, or n_ent when absent
  function automatic int unsigned find_key(input logic [KEY_W-1:0] k);
    for (int unsigned i = 0; i < n_ent; i++) begin
      if (key_tab[i] == k) return i;
    end
    return n_ent;
  endfunction

  function automatic list_resp_t apply_req(input logic [ACT_W-1:0]   act,
                                           input logic [KEY_W-1:0]   k,
                                           input logic [GRADE_W-1:0] g);
    list_resp_t  r;
    int unsigned lim;
    int unsigned hit;
    int unsigned sum;
    r   = '0;
    lim = (cap_q > DEPTH) ? DEPTH : cap_q;
    hit = find_key(k);
    case (act)
      ACT_APPEND: begin
        if (n_ent < lim) begin
          key_tab[n_ent]   = k;
          grade_tab[n_ent] = g;
          n_ent++;
        end else begin
          r.status = ST_FULL;
        end
      end
      ACT_REMOVE: begin
        if (hit < n_ent) begin
          // close the gap, later entries keep their order
          for (int unsigned j = hit; j + 1 < n_ent; j++) begin
            key_tab[j]   = key_tab[j+1];
            grade_tab[j] = grade_tab[j+1];
          end
          n_ent--;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      ACT_POP: begin
        if (n_ent > 0) n_ent--;
        else r.status = ST_EMPTY;
      end
      ACT_SEARCH: begin
        if (hit < n_ent) r.found_index = IDX_W'(hit);
        else r.status = ST_NOTFOUND;
      end
      ACT_AVERAGE: begin
        if (n_ent > 0) begin
          sum = 0;
          for (int unsigned j = 0; j < n_ent; j++) sum += grade_tab[j];
          r.mean_grade = GRADE_W'(sum / n_ent);
        end
      end
      default: ;  // undefined codes leave the list alone
    endcase
    r.entry_count = ECNT_W'(n_ent);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    list_resp_t got;
    list_resp_t want;
    if (!rst_n) begin
      n_ent = 0;
      cap_q = CAP_RST;
      resp_q.delete();
      fail_cnt  = 0;
      req_cnt   = 0;
      full_cnt  = 0;
      miss_cnt  = 0;
      empty_cnt = 0;
      pend_cnt <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_q = cfg_data;
      // compare before taking a new request: a result never belongs to a
      // request accepted on the same edge
      if (out_tvalid && out_tready) begin
        got.status      = status_t'(out_tuser);
        got.found_index = out_tdata[IDX_W-1:0];
        got.entry_count = out_tdata[IDX_W +: ECNT_W];
        got.mean_grade  = out_tdata[IDX_W+ECNT_W +: GRADE_W];
        if (resp_q.size() == 0) begin
          $display("t=%0t unexpected result: status %0d count %0d", $time,
                   got.status, got.entry_count);
          fail_cnt++;
        end else begin
          want = resp_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("found_index", want.found_index, got.found_index);
          check_field("entry_count", want.entry_count, got.entry_count);
          check_field("mean_grade", want.mean_grade, got.mean_grade);
          case (want.status)
            ST_FULL:     full_cnt++;
            ST_NOTFOUND: miss_cnt++;
            ST_EMPTY:    empty_cnt++;
            default: ;
          endcase
        end
      end
      if (in_tvalid && in_tready) begin
        resp_q.push_back(apply_req(in_tuser, in_tdata[KEY_W-1:0],
                                   in_tdata[KEY_W +: GRADE_W]));
        req_cnt++;
      end
      pend_cnt <= resp_q.size();
    end
  end

endmodule

@@ bench/bounded_array_list_with_search_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the bounded array list: clock, reset, request, config and
// result-side drivers plus the run sequence and verdict.
// Depends on bals_pkg, bounded_array_list_with_search_top and bals_list_checker.
module bounded_array_list_with_search_top_tb;
  import bals_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NOP_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_NOP_LAST  = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 200;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [47:0]         in_tdata;   // key[31:0], grade[47:32]
  logic [ACT_W-1:0]    in_tuser;   // action[2:0]
  logic                out_tvalid;
  logic                out_tready;
  logic [31:0]         out_tdata;  // found_index[5:0], entry_count[12:6], mean_grade[28:13]
  logic [STAT_W-1:0]   out_tuser;  // status[1:0]

  int unsigned fail_cnt, pend_cnt, req_cnt, full_cnt, miss_cnt, empty_cnt;

  bit idle_en  = 1'b1;
  bit hold_req = 1'b0;

  // small key pool so that searches and removals hit often
  logic [KEY_W-1:0] key_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                     32'h7FFF_FFFF, 32'h0000_0001, 32'h5A5A_A5A5,
                                     32'h1234_5678, 32'hC0DE_0042};

  always #1 clk = ~clk;

  bounded_array_list_with_search_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  bals_list_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_cnt   (fail_cnt),
    .pend_cnt   (pend_cnt),
    .req_cnt    (req_cnt),
    .full_cnt   (full_cnt),
    .miss_cnt   (miss_cnt),
    .empty_cnt  (empty_cnt)
  );

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  function automatic logic [GRADE_W-1:0] pick_grade();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return GRADE_W'($urandom_range(65535));
  endfunction

  task automatic send_req(input logic [ACT_W-1:0]   act,
                          input logic [KEY_W-1:0]   k,
                          input logic [GRADE_W-1:0] g);
    while (idle_en && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {g, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned app_pct);
    logic [ACT_W-1:0] act;
    int unsigned      roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      act = ACT_W'($urandom_range(ACT_NOP_LAST, ACT_NOP_FIRST));
    end else if (roll < 3 + app_pct) begin
      act = ACT_APPEND;
    end else begin
      case ($urandom_range(3))
        0:       act = ACT_REMOVE;
        1:       act = ACT_POP;
        2:       act = ACT_SEARCH;
        default: act = ACT_AVERAGE;
      endcase
    end
    send_req(act, pick_key(), pick_grade());
  endtask

  // every request answers, so an empty scoreboard means the block is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n,
                           input int unsigned app_pct);
    write_cap(cap);
    repeat (n) send_random(app_pct);
  endtask

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= !(idle_en && $urandom_range(99) < 6);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", pend_cnt);
    $display("bounded_array_list_with_search_top_tb failed");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corners
    send_req(ACT_POP,     32'h0000_0000, 16'h0000);
    send_req(ACT_AVERAGE, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(ACT_SEARCH,  32'h0000_0000, 16'h0000);
    send_req(ACT_REMOVE,  32'h8000_0000, 16'h0000);
    // key and grade extremes, one duplicate key
    send_req(ACT_APPEND,  32'h8000_0000, 16'h0000);
    send_req(ACT_APPEND,  32'h7FFF_FFFF, 16'hFFFF);
    send_req(ACT_APPEND,  32'hFFFF_FFFF, 16'h1234);
    send_req(ACT_APPEND,  32'h0000_0000, 16'hFFFF);
    send_req(ACT_APPEND,  32'h7FFF_FFFF, 16'h0005);
    send_req(ACT_SEARCH,  32'h7FFF_FFFF, 16'h0000);
    send_req(ACT_SEARCH,  32'h0000_0000, 16'hFFFF);
    send_req(ACT_SEARCH,  32'h1234_5678, 16'h0000);
    send_req(ACT_AVERAGE, 32'h0000_0000, 16'h0000);
    // removes the first copy from the middle; the second one moves down
    send_req(ACT_REMOVE,  32'h7FFF_FFFF, 16'h0000);
    send_req(ACT_SEARCH,  32'h7FFF_FFFF, 16'h0000);
    for (int a = ACT_NOP_FIRST; a <= ACT_NOP_LAST; a++)
      send_req(ACT_W'(a), $urandom(), GRADE_W'($urandom()));
    send_req(ACT_POP,     32'h0000_0000, 16'h0000);
    send_req(ACT_AVERAGE, 32'h0000_0000, 16'h0000);
    // capacity below the current count, zero, and above DEPTH
    write_cap(7'd2);
    send_req(ACT_APPEND, 32'h0000_0001, 16'h0001);
    write_cap(7'd0);
    send_req(ACT_APPEND, 32'h0000_0002, 16'h0002);
    write_cap(7'd127);
    send_req(ACT_APPEND, 32'h0000_0003, 16'hFFFF);

    run_phase(7'd127, 150, 70);  // grows into saturation at DEPTH
    run_phase(7'd10, 40, 30);    // capacity below count
    run_phase(7'd0, 30, 40);

    // long stretch with no idling, a result-side hold-off and a full pause
    write_cap(CAP_RST);
    idle_en = 1'b0;
    repeat (20) send_random(50);
    hold_req = 1'b1;
    repeat (30) send_random(50);
    drain();
    repeat (70) send_random(50);
    idle_en = 1'b1;

    run_phase(7'd3, 60, 50);
    run_phase(7'd100, 80, 55);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests over capacities 0..127 incl. saturation and shrink",
             req_cnt);
    $display("statuses seen: list full %0d, key not found %0d, list empty %0d",
             full_cnt, miss_cnt, empty_cnt);
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("bounded_array_list_with_search_top_tb passed");
    end else begin
      $display("bounded_array_list_with_search_top_tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bals_pkg.sv
hw/rtl/bals_cell.sv
hw/rtl/bals_div.sv
hw/rtl/bounded_array_list_with_search_top.sv
bench/bals_list_checker.sv
bench/bounded_array_list_with_search_top_tb.sv
